### sv/ccot_pkg.sv
// Shared types and constants for the capsule pair overlap test.
package ccot_pkg;

  localparam int COORD_BITS = 16;
  localparam int PACK_BITS  = 48;
  localparam int RAD_BITS   = 16;
  localparam int LIMIT_BITS = 36;
  localparam int DIST_BITS  = 34;
  localparam int PARAM_BITS = 17;
  localparam int Q_BITS     = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SQ_BITS    = 2 * COORD_BITS + 2;
  localparam int DOT_BITS   = 2 * COORD_BITS + 3;
  localparam int PAIR_BITS  = 2 * DOT_BITS;
  localparam int NUM_BITS   = PAIR_BITS + 1;
  localparam int TNOM_BITS  = DOT_BITS + PARAM_BITS + 2;
  localparam int SCALE_BITS = DIFF_BITS + PARAM_BITS + 1;
  localparam int RSUM_BITS  = RAD_BITS + 1;
  localparam int RSQ_BITS   = 2 * RSUM_BITS;

  localparam logic [PARAM_BITS-1:0] ONE_Q = PARAM_BITS'(1 << Q_BITS);

  typedef logic [2:0][COORD_BITS-1:0] pt_t;
  typedef logic [2:0][DIFF_BITS-1:0]  dvec_t;

  typedef struct packed {
    logic [PACK_BITS-1:0] first_start;
    logic [PACK_BITS-1:0] first_end;
    logic [PACK_BITS-1:0] second_start;
    logic [PACK_BITS-1:0] second_end;
    logic [RAD_BITS-1:0]  first_radius;
    logic [RAD_BITS-1:0]  second_radius;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [DIST_BITS-1:0]  dist_sq;
    logic [PARAM_BITS-1:0] param_first;
    logic [PARAM_BITS-1:0] param_second;
    logic [PACK_BITS-1:0]  closest_first;
    logic [PACK_BITS-1:0]  closest_second;
  } out_item_t;

  typedef enum logic [1:0] {
    SEG_BOTH_POINTS,
    SEG_FIRST_POINT,
    SEG_SECOND_POINT,
    SEG_GENERAL
  } seg_case_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_S,
    DIV_T
  } div_dest_t;

  typedef struct packed {
    pt_t                 p1;
    pt_t                 p2;
    dvec_t               d1;
    dvec_t               d2;
    logic [RAD_BITS-1:0] r1;
    logic [RAD_BITS-1:0] r2;
  } geo_t;

  typedef struct packed {
    geo_t                 geo;
    seg_case_t            sc;
    logic [SQ_BITS-1:0]   a;
    logic [SQ_BITS-1:0]   e;
    logic [DOT_BITS-1:0]  b;
    logic [DOT_BITS-1:0]  c;
    logic [DOT_BITS-1:0]  f;
  } solve_t;

  typedef struct packed {
    geo_t                  geo;
    logic [PARAM_BITS-1:0] s;
    logic [PARAM_BITS-1:0] t;
    div_dest_t             dest;
  } refine_t;

endpackage

### sv/ccot_front.sv
// Front pipeline: edge vectors, dot products, degeneracy decision and first quotient setup.
module ccot_front import ccot_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [LIMIT_BITS-1:0]      limit,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  in_item_t                   up_item,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic signed [NUM_BITS-1:0] dn_num,
  output logic [NUM_BITS-1:0]        dn_den,
  output solve_t                     dn_side
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] ld;

  always_comb begin
    ld[STAGES-1] = !v_r[STAGES-1] || !dn_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: unpack and form the edge vectors.
  pt_t   p1_nxt, q1, p2_nxt, q2;
  dvec_t d1_nxt, d2_nxt, rv_nxt;
  geo_t  g1_r;
  dvec_t rv1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p1_nxt[k] = up_item.first_start[k*COORD_BITS +: COORD_BITS];
      q1[k]     = up_item.first_end[k*COORD_BITS +: COORD_BITS];
      p2_nxt[k] = up_item.second_start[k*COORD_BITS +: COORD_BITS];
      q2[k]     = up_item.second_end[k*COORD_BITS +: COORD_BITS];
      d1_nxt[k] = DIFF_BITS'($signed(q1[k])) - DIFF_BITS'($signed(p1_nxt[k]));
      d2_nxt[k] = DIFF_BITS'($signed(q2[k])) - DIFF_BITS'($signed(p2_nxt[k]));
      rv_nxt[k] = DIFF_BITS'($signed(p1_nxt[k])) - DIFF_BITS'($signed(p2_nxt[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      g1_r.p1 <= p1_nxt;
      g1_r.p2 <= p2_nxt;
      g1_r.d1 <= d1_nxt;
      g1_r.d2 <= d2_nxt;
      g1_r.r1 <= up_item.first_radius;
      g1_r.r2 <= up_item.second_radius;
      rv1_r   <= rv_nxt;
    end
  end

  // Stage 2: component products.
  logic signed [PROD_BITS-1:0] aa_nxt [3], ee_nxt [3], bb_nxt [3], cc_nxt [3], ff_nxt [3];
  logic signed [PROD_BITS-1:0] aa_r [3], ee_r [3], bb_r [3], cc_r [3], ff_r [3];
  geo_t g2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      aa_nxt[k] = PROD_BITS'($signed(g1_r.d1[k]) * $signed(g1_r.d1[k]));
      ee_nxt[k] = PROD_BITS'($signed(g1_r.d2[k]) * $signed(g1_r.d2[k]));
      bb_nxt[k] = PROD_BITS'($signed(g1_r.d1[k]) * $signed(g1_r.d2[k]));
      cc_nxt[k] = PROD_BITS'($signed(g1_r.d1[k]) * $signed(rv1_r[k]));
      ff_nxt[k] = PROD_BITS'($signed(g1_r.d2[k]) * $signed(rv1_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      aa_r <= aa_nxt;
      ee_r <= ee_nxt;
      bb_r <= bb_nxt;
      cc_r <= cc_nxt;
      ff_r <= ff_nxt;
      g2_r <= g1_r;
    end
  end

  // Stage 3: dot products.
  logic signed [DOT_BITS-1:0] a_sum, e_sum, b3_nxt, c3_nxt, f3_nxt;
  logic [SQ_BITS-1:0]         a3_r, e3_r;
  logic signed [DOT_BITS-1:0] b3_r, c3_r, f3_r;
  geo_t                       g3_r;

  always_comb begin
    a_sum  = DOT_BITS'(aa_r[0]) + DOT_BITS'(aa_r[1]) + DOT_BITS'(aa_r[2]);
    e_sum  = DOT_BITS'(ee_r[0]) + DOT_BITS'(ee_r[1]) + DOT_BITS'(ee_r[2]);
    b3_nxt = DOT_BITS'(bb_r[0]) + DOT_BITS'(bb_r[1]) + DOT_BITS'(bb_r[2]);
    c3_nxt = DOT_BITS'(cc_r[0]) + DOT_BITS'(cc_r[1]) + DOT_BITS'(cc_r[2]);
    f3_nxt = DOT_BITS'(ff_r[0]) + DOT_BITS'(ff_r[1]) + DOT_BITS'(ff_r[2]);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      a3_r <= SQ_BITS'(a_sum);
      e3_r <= SQ_BITS'(e_sum);
      b3_r <= b3_nxt;
      c3_r <= c3_nxt;
      f3_r <= f3_nxt;
      g3_r <= g2_r;
    end
  end

  // Stage 4: degeneracy decision and the cross products.
  logic [PAIR_BITS-1:0]        ae4_nxt, ae4_r;
  logic signed [PAIR_BITS-1:0] bb4_nxt, bf4_nxt, ce4_nxt, bb4_r, bf4_r, ce4_r;
  seg_case_t                   sc4_nxt;
  solve_t                      side4_r;
  logic                        deg_a, deg_e;

  always_comb begin
    deg_a   = a3_r <= limit;
    deg_e   = e3_r <= limit;
    ae4_nxt = PAIR_BITS'(a3_r) * PAIR_BITS'(e3_r);
    bb4_nxt = PAIR_BITS'(b3_r * b3_r);
    bf4_nxt = PAIR_BITS'(b3_r * f3_r);
    ce4_nxt = PAIR_BITS'(c3_r * $signed({1'b0, e3_r}));
    if (deg_a && deg_e) begin
      sc4_nxt = SEG_BOTH_POINTS;
    end else if (deg_a) begin
      sc4_nxt = SEG_FIRST_POINT;
    end else if (deg_e) begin
      sc4_nxt = SEG_SECOND_POINT;
    end else begin
      sc4_nxt = SEG_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      ae4_r       <= ae4_nxt;
      bb4_r       <= bb4_nxt;
      bf4_r       <= bf4_nxt;
      ce4_r       <= ce4_nxt;
      side4_r.geo <= g3_r;
      side4_r.sc  <= sc4_nxt;
      side4_r.a   <= a3_r;
      side4_r.e   <= e3_r;
      side4_r.b   <= b3_r;
      side4_r.c   <= c3_r;
      side4_r.f   <= f3_r;
    end
  end

  // Stage 5: operands of the first quotient.
  logic [NUM_BITS-1:0]        den_g, den5_nxt, den5_r;
  logic signed [NUM_BITS-1:0] num_g, num5_nxt, num5_r;
  solve_t                     side5_r;

  always_comb begin
    den_g = NUM_BITS'(ae4_r) - NUM_BITS'(bb4_r);
    num_g = NUM_BITS'(bf4_r) - NUM_BITS'(ce4_r);
    unique case (side4_r.sc)
      SEG_BOTH_POINTS: begin
        num5_nxt = '0;
        den5_nxt = NUM_BITS'(1);
      end
      SEG_FIRST_POINT: begin
        num5_nxt = NUM_BITS'($signed(side4_r.f));
        den5_nxt = NUM_BITS'(side4_r.e);
      end
      SEG_SECOND_POINT: begin
        num5_nxt = -NUM_BITS'($signed(side4_r.c));
        den5_nxt = NUM_BITS'(side4_r.a);
      end
      default: begin
        num5_nxt = (den_g == '0) ? '0 : num_g;
        den5_nxt = den_g;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      num5_r  <= num5_nxt;
      den5_r  <= den5_nxt;
      side5_r <= side4_r;
    end
  end

  assign up_stall = !ld[0];
  assign dn_valid = v_r[STAGES-1];
  assign dn_num   = num5_r;
  assign dn_den   = den5_r;
  assign dn_side  = side5_r;

endmodule

### sv/ccot_div.sv
// Pipelined restoring divider giving a clamped Q1.16 quotient, one bit per stage after the first.
module ccot_div import ccot_pkg::*; #(
  parameter int  NW     = 8,
  parameter type side_t = logic
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  logic signed [NW-1:0]  up_num,
  input  logic [NW-1:0]         up_den,
  input  side_t                 up_side,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output logic [PARAM_BITS-1:0] dn_q,
  output side_t                 dn_side
);

  localparam int STAGES = Q_BITS + 1;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] ld;
  logic [NW-1:0]     rem_r [STAGES];
  logic [NW-1:0]     den_r [STAGES];
  logic [Q_BITS-1:0] q_r   [STAGES];
  logic [STAGES-1:0] zero_r;
  logic [STAGES-1:0] one_r;
  side_t             side_r [STAGES];

  logic [NW-1:0]     rem_nxt [STAGES-1];
  logic [STAGES-2:0] bit_nxt;
  logic              zero_nxt;

  always_comb begin
    ld[STAGES-1] = !v_r[STAGES-1] || !dn_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  always_comb begin
    logic [NW:0] shifted;
    shifted = '0;
    for (int i = 0; i < STAGES - 1; i++) begin
      shifted    = {rem_r[i], 1'b0};
      bit_nxt[i] = shifted >= {1'b0, den_r[i]};
      rem_nxt[i] = bit_nxt[i] ? NW'(shifted - {1'b0, den_r[i]}) : NW'(shifted);
    end
  end

  assign zero_nxt = up_num[NW-1] || (up_num == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_r[0]  <= $unsigned(up_num);
      den_r[0]  <= up_den;
      q_r[0]    <= '0;
      zero_r[0] <= zero_nxt;
      one_r[0]  <= !zero_nxt && ($unsigned(up_num) >= up_den);
      side_r[0] <= up_side;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (ld[i]) begin
        rem_r[i]  <= rem_nxt[i-1];
        den_r[i]  <= den_r[i-1];
        q_r[i]    <= {q_r[i-1][Q_BITS-2:0], bit_nxt[i-1]};
        zero_r[i] <= zero_r[i-1];
        one_r[i]  <= one_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_comb begin
    if (zero_r[STAGES-1]) begin
      dn_q = '0;
    end else if (one_r[STAGES-1]) begin
      dn_q = ONE_Q;
    end else begin
      dn_q = PARAM_BITS'(q_r[STAGES-1]);
    end
  end

  assign up_stall = !ld[0];
  assign dn_valid = v_r[STAGES-1];
  assign dn_side  = side_r[STAGES-1];

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> !(zero_r[0] && one_r[0]))
    else $error("Quotient marked both zero and saturated.");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STAGES-1] && !zero_r[STAGES-1] && !one_r[STAGES-1])
      |-> (rem_r[STAGES-1] < den_r[STAGES-1]))
    else $error("Partial remainder has reached the divisor.");

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[STAGES-1] && dn_stall) |=> (v_r[STAGES-1] && $stable(q_r[STAGES-1])))
    else $error("Stalled quotient was lost or changed.");

endmodule

### sv/ccot_mid.sv
// Middle pipeline: second parameter numerator, clamping decision and second quotient setup.
module ccot_mid import ccot_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic [PARAM_BITS-1:0]      up_q,
  input  solve_t                     up_side,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic signed [NUM_BITS-1:0] dn_num,
  output logic [NUM_BITS-1:0]        dn_den,
  output refine_t                    dn_side
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] ld;

  always_comb begin
    ld[STAGES-1] = !v_r[STAGES-1] || !dn_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: place the first quotient and form b*s.
  logic [PARAM_BITS-1:0]       s1_nxt, t1_nxt, s1_r, t1_r;
  logic signed [TNOM_BITS-1:0] bs1_nxt, bs1_r;
  solve_t                      side1_r;

  always_comb begin
    s1_nxt = '0;
    t1_nxt = '0;
    unique case (up_side.sc) inside
      SEG_FIRST_POINT:               t1_nxt = up_q;
      SEG_SECOND_POINT, SEG_GENERAL: s1_nxt = up_q;
      default: ;
    endcase
    bs1_nxt = TNOM_BITS'($signed(up_side.b) * $signed({1'b0, s1_nxt}));
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_r    <= s1_nxt;
      t1_r    <= t1_nxt;
      bs1_r   <= bs1_nxt;
      side1_r <= up_side;
    end
  end

  // Stage 2: t numerator and denominator.
  logic signed [TNOM_BITS-1:0] tnom2_r;
  logic [TNOM_BITS-1:0]        elim2_r;
  logic [PARAM_BITS-1:0]       s2_r, t2_r;
  solve_t                      side2_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      tnom2_r <= bs1_r + (TNOM_BITS'($signed(side1_r.f)) <<< Q_BITS);
      elim2_r <= TNOM_BITS'(side1_r.e) << Q_BITS;
      s2_r    <= s1_r;
      t2_r    <= t1_r;
      side2_r <= side1_r;
    end
  end

  // Stage 3: pick the second quotient.
  logic signed [NUM_BITS-1:0] num3_nxt, num3_r;
  logic [NUM_BITS-1:0]        den3_nxt, den3_r;
  refine_t                    side3_nxt, side3_r;

  always_comb begin
    side3_nxt.geo  = side2_r.geo;
    side3_nxt.s    = s2_r;
    side3_nxt.t    = t2_r;
    side3_nxt.dest = DIV_NONE;
    num3_nxt       = '0;
    den3_nxt       = NUM_BITS'(1);
    if (side2_r.sc == SEG_GENERAL) begin
      if (tnom2_r[TNOM_BITS-1]) begin
        num3_nxt       = -NUM_BITS'($signed(side2_r.c));
        den3_nxt       = NUM_BITS'(side2_r.a);
        side3_nxt.t    = '0;
        side3_nxt.dest = DIV_S;
      end else if ($unsigned(tnom2_r) > elim2_r) begin
        num3_nxt       = NUM_BITS'($signed(side2_r.b)) - NUM_BITS'($signed(side2_r.c));
        den3_nxt       = NUM_BITS'(side2_r.a);
        side3_nxt.t    = ONE_Q;
        side3_nxt.dest = DIV_S;
      end else begin
        num3_nxt       = NUM_BITS'(tnom2_r);
        den3_nxt       = NUM_BITS'(elim2_r);
        side3_nxt.dest = DIV_T;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      num3_r  <= num3_nxt;
      den3_r  <= den3_nxt;
      side3_r <= side3_nxt;
    end
  end

  assign up_stall = !ld[0];
  assign dn_valid = v_r[STAGES-1];
  assign dn_num   = num3_r;
  assign dn_den   = den3_r;
  assign dn_side  = side3_r;

endmodule

### sv/ccot_back.sv
// Back pipeline: closest points, squared distance, overlap flag and output register.
module ccot_back import ccot_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  logic [PARAM_BITS-1:0] up_q,
  input  refine_t               up_side,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output out_item_t             dn_item
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] ld;

  always_comb begin
    ld[STAGES-1] = !v_r[STAGES-1] || !dn_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: final parameters and scaled edge vectors.
  logic [PARAM_BITS-1:0]        s1_nxt, t1_nxt, s1_r, t1_r;
  logic signed [SCALE_BITS-1:0] ps1_nxt [3], pt1_nxt [3], ps1_r [3], pt1_r [3];
  geo_t                         g1_r;

  always_comb begin
    s1_nxt = up_side.s;
    t1_nxt = up_side.t;
    unique case (up_side.dest)
      DIV_S:   s1_nxt = up_q;
      DIV_T:   t1_nxt = up_q;
      default: ;
    endcase
    for (int k = 0; k < 3; k++) begin
      ps1_nxt[k] = SCALE_BITS'($signed(up_side.geo.d1[k]) * $signed({1'b0, s1_nxt}));
      pt1_nxt[k] = SCALE_BITS'($signed(up_side.geo.d2[k]) * $signed({1'b0, t1_nxt}));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_r  <= s1_nxt;
      t1_r  <= t1_nxt;
      ps1_r <= ps1_nxt;
      pt1_r <= pt1_nxt;
      g1_r  <= up_side.geo;
    end
  end

  // Stage 2: closest points with floor rounding, radius sum.
  pt_t                   c1_nxt, c2_nxt, c1_r, c2_r;
  logic [RSUM_BITS-1:0]  rad2_r;
  logic [PARAM_BITS-1:0] s2_r, t2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c1_nxt[k] = COORD_BITS'($signed(g1_r.p1[k]) + $signed(ps1_r[k][SCALE_BITS-1:Q_BITS]));
      c2_nxt[k] = COORD_BITS'($signed(g1_r.p2[k]) + $signed(pt1_r[k][SCALE_BITS-1:Q_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      rad2_r <= RSUM_BITS'(g1_r.r1) + RSUM_BITS'(g1_r.r2);
      s2_r   <= s1_r;
      t2_r   <= t1_r;
    end
  end

  // Stage 3: component squares.
  logic [DIFF_BITS-1:0]  dd_nxt [3];
  logic [PROD_BITS-1:0]  sq3_nxt [3], sq3_r [3];
  logic [RSQ_BITS-1:0]   rsq3_r;
  pt_t                   c1_3_r, c2_3_r;
  logic [PARAM_BITS-1:0] s3_r, t3_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd_nxt[k]  = DIFF_BITS'($signed(c1_r[k])) - DIFF_BITS'($signed(c2_r[k]));
      sq3_nxt[k] = PROD_BITS'($signed(dd_nxt[k]) * $signed(dd_nxt[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sq3_r  <= sq3_nxt;
      rsq3_r <= RSQ_BITS'(rad2_r) * RSQ_BITS'(rad2_r);
      c1_3_r <= c1_r;
      c2_3_r <= c2_r;
      s3_r   <= s2_r;
      t3_r   <= t2_r;
    end
  end

  // Stage 4: distance, overlap flag, output register.
  logic [SQ_BITS-1:0] dist_nxt;
  out_item_t          item_r;

  assign dist_nxt = SQ_BITS'(sq3_r[0]) + SQ_BITS'(sq3_r[1]) + SQ_BITS'(sq3_r[2]);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      item_r.hit            <= dist_nxt <= rsq3_r;
      item_r.dist_sq        <= DIST_BITS'(dist_nxt);
      item_r.param_first    <= s3_r;
      item_r.param_second   <= t3_r;
      item_r.closest_first  <= PACK_BITS'(c1_3_r);
      item_r.closest_second <= PACK_BITS'(c2_3_r);
    end
  end

  assign up_stall = !ld[0];
  assign dn_valid = v_r[STAGES-1];
  assign dn_item  = item_r;

endmodule

### sv/capsule_capsule_overlap_test.sv
// Top level of the capsule pair overlap test: configuration register and pipeline assembly.
//
//   channel  direction  handshake             payload
//   in_      inbound    in_valid / in_stall   in_item (in_item_t)
//   out_     outbound   out_valid / out_stall out_item (out_item_t)
//   cfg_     inbound    cfg_valid / cfg_ready cfg_data (degenerate limit)
//
// One transaction is accepted per cycle when the input is not stalled; each result passes through
// the two 17-stage quotient pipelines plus twelve arithmetic stages.
// Reset clears every valid bit and sets the degenerate limit to zero.
// A stage holds only while it is full and the stage after it cannot take its contents,
// so empty stages keep filling while the output is stalled.
module capsule_capsule_overlap_test import ccot_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_BITS-1:0] cfg_data
);

  logic [LIMIT_BITS-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  logic                       f_valid, f_stall;
  logic signed [NUM_BITS-1:0] f_num;
  logic [NUM_BITS-1:0]        f_den;
  solve_t                     f_side;

  logic                  d1_valid, d1_stall;
  logic [PARAM_BITS-1:0] d1_q;
  solve_t                d1_side;

  logic                       m_valid, m_stall;
  logic signed [NUM_BITS-1:0] m_num;
  logic [NUM_BITS-1:0]        m_den;
  refine_t                    m_side;

  logic                  d2_valid, d2_stall;
  logic [PARAM_BITS-1:0] d2_q;
  refine_t               d2_side;

  ccot_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_item  (in_item),
    .dn_valid (f_valid),
    .dn_stall (f_stall),
    .dn_num   (f_num),
    .dn_den   (f_den),
    .dn_side  (f_side)
  );

  ccot_div #(.NW(NUM_BITS), .side_t(solve_t)) u_div_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_stall (f_stall),
    .up_num   (f_num),
    .up_den   (f_den),
    .up_side  (f_side),
    .dn_valid (d1_valid),
    .dn_stall (d1_stall),
    .dn_q     (d1_q),
    .dn_side  (d1_side)
  );

  ccot_mid u_mid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d1_valid),
    .up_stall (d1_stall),
    .up_q     (d1_q),
    .up_side  (d1_side),
    .dn_valid (m_valid),
    .dn_stall (m_stall),
    .dn_num   (m_num),
    .dn_den   (m_den),
    .dn_side  (m_side)
  );

  ccot_div #(.NW(NUM_BITS), .side_t(refine_t)) u_div_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (m_valid),
    .up_stall (m_stall),
    .up_num   (m_num),
    .up_den   (m_den),
    .up_side  (m_side),
    .dn_valid (d2_valid),
    .dn_stall (d2_stall),
    .dn_q     (d2_q),
    .dn_side  (d2_side)
  );

  ccot_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d2_valid),
    .up_stall (d2_stall),
    .up_q     (d2_q),
    .up_side  (d2_side),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_item  (out_item)
  );

  a_params_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.param_first <= ONE_Q && out_item.param_second <= ONE_Q))
    else $error("Segment parameter exceeds one.");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result presented straight after reset.");

endmodule
